/* rtl/tspp_pkg.sv */
package tspp_pkg;

  localparam int unsigned TICK_RATE_SCALE = 32'd1073741824;
  localparam int unsigned NUM_AXES        = 3;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 27;
  localparam int unsigned TICKS_W    = 27;
  localparam int unsigned RATE_W     = 20;
  localparam int unsigned ACC_W      = 20;

  localparam logic [CFG_IDX_W-1:0] CFG_TICKS     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_RATE_BASE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ACC_BASE  = 3'd4;

  localparam logic [TICKS_W-1:0] TICKS_RST = 27'd10000;
  localparam logic [RATE_W-1:0]  RATE_RST  = 20'd10000;
  localparam logic [ACC_W-1:0]   ACC_RST   = 20'd1000;

  localparam int unsigned Q_DEPTH   = 2;
  localparam int unsigned DIV_NUM_W = 96;
  localparam int unsigned DIV_DEN_W = 64;
  localparam int unsigned DIV_STEPS = DIV_NUM_W;
  localparam int unsigned NUM_LANES = 4;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_BUSY = 2'd1,
    ST_ZERO = 2'd2
  } status_e;

  typedef struct packed {
    logic               linear;
    status_e            status;
    logic [30:0]        steps;
    logic [31:0]        mv_dist;
    logic [31:0]        entry;
    logic [31:0]        exit_spd;
    logic [31:0]        req;
    logic [31:0]        cap;
    logic [ACC_W-1:0]   accl;
  } job_t;

  typedef struct packed {
    logic load;
    logic step;
  } div_ctl_t;

endpackage

/* rtl/tspp_div.sv */
module tspp_div (
  input  logic                             clk_i,
  input  tspp_pkg::div_ctl_t               ctl_i,
  input  logic [tspp_pkg::DIV_NUM_W-1:0]   num_i,
  input  logic [tspp_pkg::DIV_DEN_W-1:0]   den_i,
  output logic [tspp_pkg::DIV_NUM_W-1:0]   quo_o,
  output logic [tspp_pkg::DIV_DEN_W-1:0]   rem_o
);

  localparam int unsigned NW = tspp_pkg::DIV_NUM_W;
  localparam int unsigned DW = tspp_pkg::DIV_DEN_W;

  // numerator shifts out the top while quotient bits shift in at the bottom
  logic [NW-1:0] nq_q;
  logic [DW-1:0] rem_q;
  logic [DW-1:0] den_q;
  logic [DW:0]   trial;
  logic [DW:0]   diff;
  logic          ge;

  assign trial = {rem_q, nq_q[NW-1]};
  assign diff  = trial - {1'b0, den_q};
  assign ge    = trial >= {1'b0, den_q};

  always_ff @(posedge clk_i) begin
    if (ctl_i.load) begin
      nq_q  <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (ctl_i.step) begin
      nq_q  <= {nq_q[NW-2:0], ge};
      rem_q <= ge ? diff[DW-1:0] : trial[DW-1:0];
    end
  end

  assign quo_o = nq_q;
  assign rem_o = rem_q;

endmodule

/* rtl/tspp_fifo.sv */
module tspp_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  tspp_pkg::job_t data_i,
  input  logic           pop_i,
  output logic           full_o,
  output logic           valid_o,
  output tspp_pkg::job_t data_o
);

  localparam int unsigned DEPTH = tspp_pkg::Q_DEPTH;
  localparam int unsigned PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW    = $clog2(DEPTH + 1);

  tspp_pkg::job_t mem_q [DEPTH];
  logic [PW-1:0]  wr_q;
  logic [PW-1:0]  rd_q;
  logic [CW-1:0]  cnt_q;

  assign full_o  = cnt_q == CW'(DEPTH);
  assign valid_o = cnt_q != '0;
  assign data_o  = mem_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == PW'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
      end
      if (pop_i) begin
        rd_q <= (rd_q == PW'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
      end
      if (push_i && !pop_i) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (pop_i && !push_i) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

/* rtl/tspp_front.sv */
module tspp_front #(
  parameter int unsigned NUM_AXES = tspp_pkg::NUM_AXES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tspp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tspp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic                              block_busy_i,
  input  logic [1:0]                        dominant_axis_i,
  input  logic signed [31:0]                dominant_steps_i,
  input  logic [31:0]                       move_distance_i,
  input  logic [31:0]                       entry_speed_i,
  input  logic [31:0]                       exit_speed_i,
  input  logic [31:0]                       requested_speed_i,
  input  logic                              full_i,
  output logic                              push_o,
  output tspp_pkg::job_t                    job_o,
  output logic [tspp_pkg::TICKS_W-1:0]      ticks_o
);

  localparam int unsigned AXW = (NUM_AXES > 1) ? $clog2(NUM_AXES) : 1;

  logic [tspp_pkg::TICKS_W-1:0] tps_q;
  logic [tspp_pkg::RATE_W-1:0]  rate_q [NUM_AXES];
  logic [tspp_pkg::ACC_W-1:0]   accm_q [NUM_AXES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tps_q <= tspp_pkg::TICKS_RST;
      for (int a = 0; a < NUM_AXES; a++) begin
        rate_q[a] <= tspp_pkg::RATE_RST;
        accm_q[a] <= tspp_pkg::ACC_RST;
      end
    end else if (cfg_we_i) begin
      if (cfg_idx_i == tspp_pkg::CFG_TICKS) begin
        tps_q <= cfg_data_i[tspp_pkg::TICKS_W-1:0];
      end
      for (int a = 0; a < NUM_AXES; a++) begin
        if (cfg_idx_i == tspp_pkg::CFG_IDX_W'(tspp_pkg::CFG_RATE_BASE + a)) begin
          rate_q[a] <= cfg_data_i[tspp_pkg::RATE_W-1:0];
        end
        if (cfg_idx_i == tspp_pkg::CFG_IDX_W'(tspp_pkg::CFG_ACC_BASE + a)) begin
          accm_q[a] <= cfg_data_i[tspp_pkg::ACC_W-1:0];
        end
      end
    end
  end

  assign ticks_o = (tps_q == '0) ? tspp_pkg::TICKS_W'(1) : tps_q;

  logic [31:0]    raw;
  logic [31:0]    mag;
  logic [30:0]    steps;
  logic [AXW-1:0] ax;

  assign raw = dominant_steps_i;

  always_comb begin
    mag   = raw[31] ? (~raw + 32'd1) : raw;
    // most negative count saturates to the largest magnitude
    steps = mag[31] ? '1 : mag[30:0];
    if (32'(dominant_axis_i) >= 32'(NUM_AXES)) begin
      ax = AXW'(NUM_AXES - 1);
    end else begin
      ax = AXW'(dominant_axis_i);
    end
  end

  always_comb begin
    job_o.linear   = func_i;
    job_o.steps    = steps;
    job_o.mv_dist  = (move_distance_i == '0) ? 32'd1 : move_distance_i;
    job_o.entry    = entry_speed_i;
    job_o.exit_spd = exit_speed_i;
    job_o.req      = requested_speed_i;
    job_o.cap      = {rate_q[ax], 12'b0};
    job_o.accl     = (accm_q[ax] == '0) ? tspp_pkg::ACC_W'(1) : accm_q[ax];
    if (block_busy_i) begin
      job_o.status = tspp_pkg::ST_BUSY;
    end else if (steps == '0) begin
      job_o.status = tspp_pkg::ST_ZERO;
    end else begin
      job_o.status = tspp_pkg::ST_OK;
    end
  end

  assign in_stall_o = full_i;
  assign push_o     = in_valid_i && !full_i;

endmodule

/* rtl/tspp_back.sv */
module tspp_back #(
  parameter int unsigned TICK_RATE_SCALE = tspp_pkg::TICK_RATE_SCALE
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          fifo_valid_i,
  input  tspp_pkg::job_t                fifo_data_i,
  output logic                          pop_o,
  input  logic [tspp_pkg::TICKS_W-1:0]  ticks_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic [1:0]                    status_o,
  output logic [31:0]                   initial_rate_o,
  output logic [31:0]                   peak_rate_o,
  output logic [31:0]                   final_rate_o,
  output logic [31:0]                   accel_rate_o,
  output logic [30:0]                   steps_before_decel_o
);

  localparam int unsigned NW = tspp_pkg::DIV_NUM_W;
  localparam int unsigned DW = tspp_pkg::DIV_DEN_W;
  localparam int unsigned NL = tspp_pkg::NUM_LANES;
  localparam int unsigned CW = $clog2(tspp_pkg::DIV_STEPS);
  localparam int unsigned SQRT_STEPS = 32;
  localparam logic [31:0] TS = 32'(TICK_RATE_SCALE);

  typedef enum logic [18:0] {
    B_IDLE  = 19'h00001,
    B_LIN   = 19'h00002,
    B_MUL_A = 19'h00004,
    B_LD_A  = 19'h00008,
    B_DIV_A = 19'h00010,
    B_SAT_A = 19'h00020,
    B_SQR   = 19'h00040,
    B_LD_C  = 19'h00080,
    B_DIV_C = 19'h00100,
    B_SPLIT = 19'h00200,
    B_CMP   = 19'h00400,
    B_PROD  = 19'h00800,
    B_PSUM  = 19'h01000,
    B_RADD  = 19'h02000,
    B_SQRT  = 19'h04000,
    B_MUL_E = 19'h08000,
    B_LD_E  = 19'h10000,
    B_DIV_E = 19'h20000,
    B_FIN   = 19'h40000
  } bst_e;

  bst_e           state_q;
  logic [CW-1:0]  cnt_q;
  tspp_pkg::job_t job_q;
  logic [31:0]    vi_q, vf_q, vp_q;
  logic [63:0]    acc_q, i2_q, f2_q, p2_q, ph_q, mp_q;
  logic [63:0]    pa_q [NL];
  logic           plus_q;
  logic [30:0]    acs_q, sbd_q;
  logic [63:0]    sv_q, sres_q, sbit_q;

  logic           out_valid_q;
  logic [1:0]     status_q;
  logic [31:0]    irate_q, prate_q, frate_q, arate_q;
  logic [30:0]    sbd_out_q;

  // divider lanes
  tspp_pkg::div_ctl_t dctl;
  logic [NW-1:0] lnum [NL];
  logic [DW-1:0] lden [NL];
  logic [NW-1:0] lquo [NL];
  logic [DW-1:0] lrem [NL];

  for (genvar g = 0; g < NL; g++) begin : g_lane
    tspp_div u_div (
      .clk_i (clk_i),
      .ctl_i (dctl),
      .num_i (lnum[g]),
      .den_i (lden[g]),
      .quo_o (lquo[g]),
      .rem_o (lrem[g])
    );
  end

  assign dctl.load = (state_q == B_LD_A) || (state_q == B_LD_C) || (state_q == B_LD_E);
  assign dctl.step = (state_q == B_DIV_A) || (state_q == B_DIV_C) || (state_q == B_DIV_E);

  logic [36:0] t1k;
  logic [95:0] acc_ts;
  assign t1k    = 37'(ticks_i) * 37'd1000;
  assign acc_ts = {ph_q, 32'b0} + {32'b0, pa_q[3]};

  always_comb begin
    for (int k = 0; k < NL; k++) begin
      lnum[k] = '0;
      lden[k] = '0;
    end
    case (state_q)
      B_LD_A: begin
        lnum[0] = {20'b0, pa_q[0], 12'b0};
        lnum[1] = {20'b0, pa_q[1], 12'b0};
        lnum[2] = {20'b0, pa_q[2], 12'b0};
        lnum[3] = {4'b0, pa_q[3], 28'b0};
        for (int k = 0; k < NL; k++) begin
          lden[k] = {32'b0, job_q.mv_dist};
        end
      end
      B_LD_C: begin
        lnum[0] = {32'b0, (f2_q >= i2_q) ? (f2_q - i2_q) : (i2_q - f2_q)};
        lnum[1] = {32'b0, (vp_q > vi_q) ? (p2_q - i2_q) : 64'd0};
        lnum[2] = {32'b0, (vp_q > vf_q) ? (p2_q - f2_q) : 64'd0};
        for (int k = 0; k < NL; k++) begin
          lden[k] = acc_q;
        end
      end
      B_LD_E: begin
        lnum[0] = {32'b0, pa_q[0]};
        lnum[1] = {32'b0, pa_q[1]};
        lnum[2] = {32'b0, pa_q[2]};
        lnum[3] = acc_ts;
        lden[0] = {25'b0, ticks_i, 12'b0};
        lden[1] = {25'b0, ticks_i, 12'b0};
        lden[2] = {25'b0, ticks_i, 12'b0};
        lden[3] = {15'b0, t1k, 12'b0};
      end
      default: ;
    endcase
  end

  // shared multiplier
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_q)
      B_MUL_A: begin
        mul_b = {1'b0, job_q.steps};
        case (cnt_q[1:0])
          2'd0:    mul_a = job_q.entry;
          2'd1:    mul_a = job_q.exit_spd;
          2'd2:    mul_a = job_q.req;
          default: mul_a = {12'b0, job_q.accl};
        endcase
      end
      B_SQR: begin
        case (cnt_q[1:0])
          2'd0:    mul_a = vi_q;
          2'd1:    mul_a = vf_q;
          default: mul_a = vp_q;
        endcase
        mul_b = mul_a;
      end
      B_PROD: begin
        mul_a = cnt_q[0] ? acc_q[63:32] : acc_q[31:0];
        mul_b = {1'b0, acs_q};
      end
      B_MUL_E: begin
        mul_b = TS;
        case (cnt_q[2:0])
          3'd0:    mul_a = vi_q;
          3'd1:    mul_a = vp_q;
          3'd2:    mul_a = vf_q;
          3'd3:    mul_a = acc_q[31:0];
          default: mul_a = acc_q[63:32];
        endcase
      end
      default: ;
    endcase
  end

  // split of accelerating steps
  logic [30:0] half;
  logic        rnd;
  logic [50:0] cup;
  logic [51:0] sum52;
  logic [49:0] fl;
  logic [30:0] acs_n;
  logic [50:0] tomax, dec;

  always_comb begin
    half  = {1'b0, job_q.steps[30:1]};
    rnd   = (|lquo[0][13:0]) || (|lrem[0]);
    cup   = {1'b0, lquo[0][63:14]} + 51'(rnd);
    sum52 = 52'(half) + 52'(cup);
    fl    = lquo[0][63:14];
    if (plus_q) begin
      acs_n = (sum52 > 52'(job_q.steps)) ? job_q.steps : sum52[30:0];
    end else begin
      acs_n = (fl >= 50'(half)) ? 31'd0 : (half - fl[30:0]);
    end
    tomax = lquo[1][63:13];
    dec   = lquo[2][63:13];
  end

  logic [95:0] full96;
  logic [63:0] t13;
  logic [64:0] sum65;
  logic [63:0] rb;
  logic        sq_ge;
  logic [63:0] sres_n;

  assign full96 = {pa_q[1], 32'b0} + {32'b0, pa_q[0]};
  assign t13    = (|mp_q[63:51]) ? '1 : {mp_q[50:0], 13'b0};
  assign sum65  = {1'b0, i2_q} + {1'b0, t13};
  assign rb     = sres_q + sbit_q;
  assign sq_ge  = sv_q >= rb;
  assign sres_n = sq_ge ? ((sres_q >> 1) + sbit_q) : (sres_q >> 1);

  logic [31:0] lin_v;
  assign lin_v = ({4'b0, job_q.req[31:4]} > job_q.cap) ? job_q.cap
                                                       : {4'b0, job_q.req[31:4]};

  logic fin_load;
  assign fin_load = (state_q == B_FIN) && (!out_valid_q || !out_stall_i);
  assign pop_o    = (state_q == B_IDLE) && fifo_valid_i;

  function automatic logic [31:0] sat_lim(logic [NW-1:0] q, logic [31:0] lim);
    sat_lim = (q > {64'b0, lim}) ? lim : q[31:0];
  endfunction

  function automatic logic [31:0] sat32(logic [NW-1:0] q);
    sat32 = (|q[NW-1:32]) ? '1 : q[31:0];
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= B_IDLE;
      cnt_q   <= '0;
    end else begin
      case (state_q)
        B_IDLE: begin
          cnt_q <= '0;
          if (fifo_valid_i) begin
            if (fifo_data_i.status != tspp_pkg::ST_OK) begin
              state_q <= B_FIN;
            end else if (fifo_data_i.linear) begin
              state_q <= B_LIN;
            end else begin
              state_q <= B_MUL_A;
            end
          end
        end
        B_LIN: begin
          cnt_q   <= '0;
          state_q <= B_MUL_E;
        end
        B_MUL_A: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(3)) begin
            state_q <= B_LD_A;
          end
        end
        B_LD_A: begin
          cnt_q   <= '0;
          state_q <= B_DIV_A;
        end
        B_DIV_A: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(tspp_pkg::DIV_STEPS - 1)) begin
            state_q <= B_SAT_A;
          end
        end
        B_SAT_A: begin
          cnt_q   <= '0;
          state_q <= B_SQR;
        end
        B_SQR: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(2)) begin
            state_q <= B_LD_C;
          end
        end
        B_LD_C: begin
          cnt_q   <= '0;
          state_q <= B_DIV_C;
        end
        B_DIV_C: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(tspp_pkg::DIV_STEPS - 1)) begin
            state_q <= B_SPLIT;
          end
        end
        B_SPLIT: begin
          state_q <= B_CMP;
        end
        B_CMP: begin
          cnt_q <= '0;
          if (51'(acs_q) > tomax) begin
            state_q <= B_MUL_E;
          end else begin
            state_q <= B_PROD;
          end
        end
        B_PROD: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(1)) begin
            state_q <= B_PSUM;
          end
        end
        B_PSUM: begin
          state_q <= B_RADD;
        end
        B_RADD: begin
          cnt_q   <= '0;
          state_q <= B_SQRT;
        end
        B_SQRT: begin
          if (cnt_q == CW'(SQRT_STEPS - 1)) begin
            cnt_q   <= '0;
            state_q <= B_MUL_E;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        B_MUL_E: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(4)) begin
            state_q <= B_LD_E;
          end
        end
        B_LD_E: begin
          cnt_q   <= '0;
          state_q <= B_DIV_E;
        end
        B_DIV_E: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == CW'(tspp_pkg::DIV_STEPS - 1)) begin
            state_q <= B_FIN;
          end
        end
        B_FIN: begin
          if (fin_load) begin
            state_q <= B_IDLE;
          end
        end
        default: state_q <= B_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      B_IDLE: begin
        if (fifo_valid_i) begin
          job_q <= fifo_data_i;
        end
      end
      B_LIN: begin
        vi_q  <= lin_v;
        vf_q  <= lin_v;
        vp_q  <= lin_v;
        acc_q <= {32'b0, lin_v};
        sbd_q <= job_q.steps;
      end
      B_MUL_A: begin
        pa_q[cnt_q[1:0]] <= mul_p;
      end
      B_SAT_A: begin
        vi_q <= sat_lim(lquo[0], job_q.cap);
        vf_q <= sat_lim(lquo[1], job_q.cap);
        vp_q <= sat_lim(lquo[2], job_q.cap);
        if (|lquo[3][NW-1:64]) begin
          acc_q <= '1;
        end else if (lquo[3][63:0] == '0) begin
          acc_q <= 64'd1;
        end else begin
          acc_q <= lquo[3][63:0];
        end
      end
      B_SQR: begin
        case (cnt_q[1:0])
          2'd0:    i2_q <= mul_p;
          2'd1:    f2_q <= mul_p;
          default: p2_q <= mul_p;
        endcase
      end
      B_LD_C: begin
        plus_q <= f2_q >= i2_q;
      end
      B_SPLIT: begin
        acs_q <= acs_n;
      end
      B_CMP: begin
        sbd_q <= (dec >= 51'(job_q.steps)) ? 31'd0 : (job_q.steps - dec[30:0]);
      end
      B_PROD: begin
        pa_q[cnt_q[1:0]] <= mul_p;
      end
      B_PSUM: begin
        mp_q <= (|full96[95:64]) ? '1 : full96[63:0];
      end
      B_RADD: begin
        sv_q   <= sum65[64] ? '1 : sum65[63:0];
        sres_q <= '0;
        sbit_q <= 64'h4000_0000_0000_0000;
        sbd_q  <= acs_q;
      end
      B_SQRT: begin
        if (sq_ge) begin
          sv_q <= sv_q - rb;
        end
        sres_q <= sres_n;
        sbit_q <= sbit_q >> 2;
        vp_q   <= sres_n[31:0];
      end
      B_MUL_E: begin
        if (cnt_q == CW'(4)) begin
          ph_q <= mul_p;
        end else begin
          pa_q[cnt_q[1:0]] <= mul_p;
        end
      end
      default: ;
    endcase
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fin_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fin_load) begin
      status_q <= job_q.status;
      if (job_q.status != tspp_pkg::ST_OK) begin
        irate_q   <= '0;
        prate_q   <= '0;
        frate_q   <= '0;
        arate_q   <= '0;
        sbd_out_q <= '0;
      end else begin
        irate_q   <= sat32(lquo[0]);
        prate_q   <= sat32(lquo[1]);
        frate_q   <= sat32(lquo[2]);
        arate_q   <= sat32(lquo[3]);
        sbd_out_q <= sbd_q;
      end
    end
  end

  assign out_valid_o          = out_valid_q;
  assign status_o             = status_q;
  assign initial_rate_o       = irate_q;
  assign peak_rate_o          = prate_q;
  assign final_rate_o         = frate_q;
  assign accel_rate_o         = arate_q;
  assign steps_before_decel_o = sbd_out_q;

endmodule

/* rtl/trapezoid_step_profile_planner_unit.sv */
// channel   dir  handshake                   payload
// in        in   in_valid_i / in_stall_o     func .. requested_speed
// out       out  out_valid_o / out_stall_i   status .. steps_before_decel
// cfg       in   cfg_we_i                    cfg_idx_i, cfg_data_i
//
// Ramped blocks make three passes through the radix-2 divider lanes and run the
// root stage when the peak comes from the square root; linear blocks make one
// pass; busy or zero-step blocks skip the datapath.
// A two-entry queue takes new beats while the back end works; a finished
// result waits in the output register under out_stall_i, and the next result waits in B_FIN until it is taken.
// Reset clears control state only; configuration resets to its defaults.
module trapezoid_step_profile_planner_unit #(
  parameter int unsigned TICK_RATE_SCALE = tspp_pkg::TICK_RATE_SCALE,
  parameter int unsigned NUM_AXES        = tspp_pkg::NUM_AXES
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tspp_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  logic [tspp_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic                              func_i,
  input  logic                              block_busy_i,
  input  logic [1:0]                        dominant_axis_i,
  input  logic signed [31:0]                dominant_steps_i,
  input  logic [31:0]                       move_distance_i,
  input  logic [31:0]                       entry_speed_i,
  input  logic [31:0]                       exit_speed_i,
  input  logic [31:0]                       requested_speed_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [1:0]                        status_o,
  output logic [31:0]                       initial_rate_o,
  output logic [31:0]                       peak_rate_o,
  output logic [31:0]                       final_rate_o,
  output logic [31:0]                       accel_rate_o,
  output logic [30:0]                       steps_before_decel_o
);

  logic                         full;
  logic                         push;
  logic                         pop;
  logic                         q_valid;
  tspp_pkg::job_t               job_in;
  tspp_pkg::job_t               job_out;
  logic [tspp_pkg::TICKS_W-1:0] ticks;

  tspp_front #(
    .NUM_AXES (NUM_AXES)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .cfg_idx_i         (cfg_idx_i),
    .cfg_data_i        (cfg_data_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .func_i            (func_i),
    .block_busy_i      (block_busy_i),
    .dominant_axis_i   (dominant_axis_i),
    .dominant_steps_i  (dominant_steps_i),
    .move_distance_i   (move_distance_i),
    .entry_speed_i     (entry_speed_i),
    .exit_speed_i      (exit_speed_i),
    .requested_speed_i (requested_speed_i),
    .full_i            (full),
    .push_o            (push),
    .job_o             (job_in),
    .ticks_o           (ticks)
  );

  tspp_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (job_in),
    .pop_i   (pop),
    .full_o  (full),
    .valid_o (q_valid),
    .data_o  (job_out)
  );

  tspp_back #(
    .TICK_RATE_SCALE (TICK_RATE_SCALE)
  ) u_back (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .fifo_valid_i         (q_valid),
    .fifo_data_i          (job_out),
    .pop_o                (pop),
    .ticks_i              (ticks),
    .out_valid_o          (out_valid_o),
    .out_stall_i          (out_stall_i),
    .status_o             (status_o),
    .initial_rate_o       (initial_rate_o),
    .peak_rate_o          (peak_rate_o),
    .final_rate_o         (final_rate_o),
    .accel_rate_o         (accel_rate_o),
    .steps_before_decel_o (steps_before_decel_o)
  );

endmodule

/* verif/tb_trapezoid_step_profile_planner_unit.sv */
module tb_trapezoid_step_profile_planner_unit;

  typedef struct {
    tspp_pkg::status_e status;
    logic [31:0] initial_rate;
    logic [31:0] peak_rate;
    logic [31:0] final_rate;
    logic [31:0] accel_rate;
    logic [30:0] steps_before_decel;
  } ramp_t;

  typedef enum logic [2:0] {
    REG_TICKS = 3'd0,
    REG_RATE0 = 3'd1,
    REG_RATE1 = 3'd2,
    REG_RATE2 = 3'd3,
    REG_ACC0  = 3'd4,
    REG_ACC1  = 3'd5,
    REG_ACC2  = 3'd6
  } reg_e;

  localparam int unsigned LIMIT = 3000000;

  int mismatches = 0;
  int unsigned cycle = 0;
  int idle_in_pct = 0;
  int stall_out_pct = 0;

  task automatic report_mismatch(string msg);
    $display("mismatch @%0d: %s", cycle, msg);
    mismatches++;
  endtask

  // Planner predictor: mirrors the block configuration and computes ramps.
  class ramp_scoreboard;
    logic [63:0] ticks;
    logic [63:0] rate_lim [3];
    logic [63:0] acc_lim [3];
    ramp_t pending_ramps[$];

    function void reset_cfg();
      ticks = 10000;
      for (int i = 0; i < 3; i++) begin
        rate_lim[i] = 10000;
        acc_lim[i] = 1000;
      end
    endfunction

    function void write_cfg(logic [2:0] idx, logic [26:0] val);
      if (idx == REG_TICKS) ticks = val;
      else if (idx >= REG_RATE0 && idx <= REG_RATE2) rate_lim[idx - REG_RATE0] = val[19:0];
      else if (idx >= REG_ACC0 && idx <= REG_ACC2) acc_lim[idx - REG_ACC0] = val[19:0];
    endfunction

    function logic [63:0] scale_div(logic [63:0] a, logic [63:0] b, logic [63:0] d,
                                    logic [63:0] lim);
      logic [127:0] q;
      if (d == 0) return lim;
      q = ({64'd0, a} * {64'd0, b}) / {64'd0, d};
      if (q > {64'd0, lim}) return lim;
      return q[63:0];
    endfunction

    function logic [63:0] root64(logic [63:0] v);
      logic [63:0] res, bit_w;
      res = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
        if (v >= res + bit_w) begin
          v -= res + bit_w;
          res = (res >> 1) + bit_w;
        end else begin
          res >>= 1;
        end
        bit_w >>= 2;
      end
      return res;
    endfunction

    function void note_block(logic lin, logic busy, logic [1:0] axis, logic [31:0] raw,
                             logic [31:0] mv_dist, logic [31:0] entry, logic [31:0] ex,
                             logic [31:0] req);
      ramp_t r;
      logic [63:0] s, cap, accl, vi, vf, vp, acc, dec, d, f2, i2, p2, tomax, acc_steps;
      logic [63:0] n, q, prod, tk;
      logic [127:0] wide;
      longint sa, h;
      int ax;
      r = '{tspp_pkg::ST_OK, 0, 0, 0, 0, 0};
      if (busy) begin
        r.status = tspp_pkg::ST_BUSY;
        pending_ramps.push_back(r);
        return;
      end
      s = raw[31] ? {32'd0, -raw} : {32'd0, raw};
      if (s > 64'h7FFFFFFF) s = 64'h7FFFFFFF;
      if (s == 0) begin
        r.status = tspp_pkg::ST_ZERO;
        pending_ramps.push_back(r);
        return;
      end
      ax = (axis > 2) ? 2 : axis;
      cap = rate_lim[ax] << 12;
      accl = acc_lim[ax] ? acc_lim[ax] : 1;
      if (lin) begin
        vi = req >> 4;
        if (vi > cap) vi = cap;
        vf = vi;
        vp = vi;
        acc = vi;
        dec = 0;
      end else begin
        d = mv_dist ? mv_dist : 1;
        h = s / 2;
        vi = scale_div(entry * s, 4096, d, cap);
        vf = scale_div(ex * s, 4096, d, cap);
        acc = scale_div(accl * s, 64'd1 << 28, d, '1);
        if (acc == 0) acc = 1;
        f2 = vf * vf;
        i2 = vi * vi;
        if (f2 >= i2) begin
          n = f2 - i2;
          q = n / acc;
          sa = h + longint'((q >> 14) + ((q[13:0] != 0 || (n % acc) != 0) ? 1 : 0));
        end else begin
          sa = h - longint'(((i2 - f2) / acc) >> 14);
        end
        if (sa <= 0) acc_steps = 0;
        else if (sa > longint'(s)) acc_steps = s;
        else acc_steps = sa;
        vp = scale_div(req * s, 4096, d, cap);
        p2 = vp * vp;
        tomax = (vp > vi) ? ((p2 - i2) / acc) >> 13 : 0;
        if (acc_steps > tomax) begin
          dec = (vp > vf) ? ((p2 - f2) / acc) >> 13 : 0;
        end else begin
          // saturating i2 + acc * steps * 8192
          wide = {64'd0, acc} * {64'd0, acc_steps} * 128'd8192;
          wide = wide + {64'd0, i2};
          prod = (wide[127:64] != 0) ? '1 : wide[63:0];
          vp = root64(prod);
          dec = s - acc_steps;
        end
      end
      tk = ticks ? ticks : 1;
      r.initial_rate = scale_div(vi, tspp_pkg::TICK_RATE_SCALE, tk << 12, 32'hFFFFFFFF);
      r.peak_rate = scale_div(vp, tspp_pkg::TICK_RATE_SCALE, tk << 12, 32'hFFFFFFFF);
      r.final_rate = scale_div(vf, tspp_pkg::TICK_RATE_SCALE, tk << 12, 32'hFFFFFFFF);
      r.accel_rate = scale_div(acc, tspp_pkg::TICK_RATE_SCALE, (tk * 1000) << 12,
                               32'hFFFFFFFF);
      r.steps_before_decel = (dec >= s) ? 0 : 31'(s - dec);
      pending_ramps.push_back(r);
    endfunction

    task check_ramp(ramp_t got);
      ramp_t e;
      if (pending_ramps.size() == 0) begin
        report_mismatch("result beat with nothing pending");
        return;
      end
      e = pending_ramps.pop_front();
      if (got.status != e.status)
        report_mismatch($sformatf("status %0d exp %0d", got.status, e.status));
      if (got.initial_rate != e.initial_rate)
        report_mismatch($sformatf("initial_rate %h exp %h", got.initial_rate, e.initial_rate));
      if (got.peak_rate != e.peak_rate)
        report_mismatch($sformatf("peak_rate %h exp %h", got.peak_rate, e.peak_rate));
      if (got.final_rate != e.final_rate)
        report_mismatch($sformatf("final_rate %h exp %h", got.final_rate, e.final_rate));
      if (got.accel_rate != e.accel_rate)
        report_mismatch($sformatf("accel_rate %h exp %h", got.accel_rate, e.accel_rate));
      if (got.steps_before_decel != e.steps_before_decel)
        report_mismatch($sformatf("steps_before_decel %h exp %h",
                                  got.steps_before_decel, e.steps_before_decel));
    endtask
  endclass

  logic clk_i = 0;
  logic rst_ni = 0;
  logic cfg_we_i = 0;
  logic [tspp_pkg::CFG_IDX_W-1:0] cfg_idx_i = '0;
  logic [tspp_pkg::CFG_DATA_W-1:0] cfg_data_i = '0;
  logic in_valid_i = 0;
  logic in_stall_o;
  logic func_i = 0;
  logic block_busy_i = 0;
  logic [1:0] dominant_axis_i = '0;
  logic signed [31:0] dominant_steps_i = '0;
  logic [31:0] move_distance_i = '0;
  logic [31:0] entry_speed_i = '0;
  logic [31:0] exit_speed_i = '0;
  logic [31:0] requested_speed_i = '0;
  logic out_valid_o;
  logic out_stall_i = 0;
  logic [1:0] status_o;
  logic [31:0] initial_rate_o, peak_rate_o, final_rate_o, accel_rate_o;
  logic [30:0] steps_before_decel_o;

  ramp_scoreboard planner = new();

  trapezoid_step_profile_planner_unit i_dut (.*);

  always begin
    #10 clk_i = 1;
    #10 clk_i = 0;
  end

  always @(posedge clk_i) begin
    cycle <= cycle + 1;
    if (cycle > LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // result side: check on accepted beats, randomize stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && !out_stall_i)
        planner.check_ramp('{tspp_pkg::status_e'(status_o), initial_rate_o, peak_rate_o,
                             final_rate_o, accel_rate_o, steps_before_decel_o});
      out_stall_i <= ($urandom_range(99) < stall_out_pct);
    end
  end

  task automatic write_reg(reg_e idx, logic [26:0] val);
    @(posedge clk_i);
    cfg_we_i <= 1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    planner.write_cfg(idx, val);
    @(posedge clk_i);
    cfg_we_i <= 0;
  endtask

  task automatic send_block(logic lin, logic busy, logic [1:0] axis, logic [31:0] steps,
                            logic [31:0] mv_dist, logic [31:0] entry, logic [31:0] ex,
                            logic [31:0] req);
    while ($urandom_range(99) < idle_in_pct) begin
      in_valid_i <= 0;
      @(posedge clk_i);
    end
    in_valid_i <= 1;
    func_i <= lin;
    block_busy_i <= busy;
    dominant_axis_i <= axis;
    dominant_steps_i <= steps;
    move_distance_i <= mv_dist;
    entry_speed_i <= entry;
    exit_speed_i <= ex;
    requested_speed_i <= req;
    do @(posedge clk_i); while (in_stall_o);
    planner.note_block(lin, busy, axis, steps, mv_dist, entry, ex, req);
  endtask

  task automatic drain();
    in_valid_i <= 0;
    while (planner.pending_ramps.size() != 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rnd_speed();
    case ($urandom_range(3))
      0: return $urandom;
      1: return $urandom_range(32'h00FFFFFF);
      2: return $urandom_range(32'h0FFFFF);
      default: return 0;
    endcase
  endfunction

  task automatic random_block();
    logic [31:0] steps, mv_dist;
    case ($urandom_range(3))
      0: steps = $urandom;
      1: steps = $urandom_range(5000);
      2: steps = -$urandom_range(5000);
      default: steps = $urandom_range(200000);
    endcase
    if ($urandom_range(49) == 0) steps = 0;
    mv_dist = $urandom_range(1) ? $urandom_range(32'h00FFFFFF) : $urandom;
    send_block($urandom_range(4) == 0, $urandom_range(19) == 0, 2'($urandom_range(3)),
               steps, mv_dist, rnd_speed(), rnd_speed(), rnd_speed());
  endtask

  task automatic random_cfg();
    write_reg(REG_TICKS, $urandom_range(1) ? 27'($urandom_range(1, 100000000))
                                           : 27'($urandom_range(100000)));
    write_reg(REG_RATE0, 27'($urandom_range(20'hFFFFF)));
    write_reg(REG_RATE1, 27'($urandom_range(50000)));
    write_reg(REG_RATE2, 27'($urandom_range(20'hFFFFF)));
    write_reg(REG_ACC0, 27'($urandom_range(1, 20'hFFFFF)));
    write_reg(REG_ACC1, 27'($urandom_range(1, 5000)));
    write_reg(REG_ACC2, 27'($urandom_range(1, 20'hFFFFF)));
  endtask

  initial begin
    planner.reset_cfg();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1;
    @(posedge clk_i);

    // directed: extremes, busy, zero steps, -2^31, axis 3, zero distance, both modes
    send_block(0, 0, 0, 1000, 32'h000A0000, 32'h00010000, 32'h00010000, 32'h00640000);
    send_block(0, 0, 1, 100, 32'h00010000, 0, 0, 32'h00320000);
    send_block(0, 0, 2, 10, 32'h00010000, 0, 0, 32'hFFFFFFFF);
    send_block(0, 1, 0, 500, 32'h00010000, 1, 1, 1);
    send_block(0, 0, 0, 0, 32'h00010000, 1, 1, 1);
    send_block(1, 0, 1, 0, 32'h00010000, 1, 1, 1);
    send_block(0, 0, 3, 32'h80000000, 32'hFFFFFFFF, '1, '1, '1);
    send_block(0, 0, 1, 32'h7FFFFFFF, 0, 32'h00001000, 32'h00002000, 32'h00100000);
    send_block(0, 0, 0, -5000, 32'h00640000, 32'h00320000, 0, 32'h00C80000);
    send_block(0, 0, 2, 3, 32'h00000001, 0, 32'hFFFFFFFF, 32'h00010000);
    send_block(1, 0, 0, 200, 0, 0, 0, 32'hFFFFFFFF);
    send_block(1, 0, 3, -1, 32'h00010000, '1, '1, 32'h000F4240);
    send_block(1, 0, 2, 1, 32'h00010000, 0, 0, 0);
    send_block(0, 0, 1, 1, 32'h00010000, 32'h00010000, 32'h00010000, 32'h00010000);
    drain();
    write_reg(REG_TICKS, 0);
    write_reg(REG_RATE0, 0);
    write_reg(REG_ACC0, 0);
    write_reg(REG_RATE1, 20'hFFFFF);
    write_reg(REG_ACC1, 20'hFFFFF);
    write_reg(REG_RATE2, 20'hFFFFF);
    write_reg(REG_ACC2, 1);
    send_block(0, 0, 0, 1000, 32'h000A0000, 32'h00010000, 32'h00010000, 32'h00640000);
    send_block(0, 0, 1, 40000, 32'h00010000, 32'hFFFFFFFF, 0, 32'hFFFFFFFF);
    send_block(0, 0, 2, 40000, 32'h00010000, 0, 0, 32'hFFFFFFFF);
    send_block(1, 0, 1, 9, 32'h00010000, 0, 0, 32'hFFFFFFFF);
    drain();
    write_reg(REG_TICKS, 27'h7FFFFFF);
    write_reg(REG_ACC2, 20'hFFFFF);
    send_block(0, 0, 2, 123456, 32'h01000000, 32'h00100000, 32'h00080000, 32'h00200000);
    send_block(1, 0, 1, 77, 32'h00010000, 0, 0, 32'h12345678);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin idle_in_pct = 0; stall_out_pct = 0; end
        1: begin idle_in_pct = 58; stall_out_pct = 0; end
        2: begin idle_in_pct = 0; stall_out_pct = 58; end
        default: begin idle_in_pct = 12; stall_out_pct = 12; end
      endcase
      if (ph == 7) begin
        planner.write_cfg(REG_TICKS, 10000);
        write_reg(REG_TICKS, 10000);
        write_reg(REG_RATE0, 10000);
        write_reg(REG_RATE1, 10000);
        write_reg(REG_RATE2, 10000);
        write_reg(REG_ACC0, 1000);
        write_reg(REG_ACC1, 1000);
        write_reg(REG_ACC2, 1000);
      end else if (ph != 0) begin
        random_cfg();
      end
      repeat (104) random_block();
      drain();
    end
    idle_in_pct = 0;
    stall_out_pct = 0;
    drain();
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end
endmodule

/* sim.f */
rtl/tspp_pkg.sv
rtl/tspp_div.sv
rtl/tspp_fifo.sv
rtl/tspp_front.sv
rtl/tspp_back.sv
rtl/trapezoid_step_profile_planner_unit.sv
verif/tb_trapezoid_step_profile_planner_unit.sv
